// ===== design/rfbt_pkg.sv =====
package rfbt_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 8;
  localparam int HANDLE_BITS_DEF = 8;
  localparam int READER_BITS_DEF = 4;

  // Fixed port field widths
  localparam int CMD_W  = 2;
  localparam int ID_W   = 8;
  localparam int KIND_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_TAKE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e_t;

  typedef enum logic [KIND_W-1:0] {
    K_RETURNED = 3'd0,
    K_STORED   = 3'd1,
    K_REJECTED = 3'd2,
    K_GRANTED  = 3'd3,
    K_EMPTY    = 3'd4,
    K_HELD     = 3'd5,
    K_NOTFOUND = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_APPEND,
    ST_GRANT,
    ST_EMPTY,
    ST_FIND,
    ST_NOTF,
    ST_SHIFT
  } state_t;

  // Table write operations
  typedef enum logic [2:0] {
    WR_NONE,
    WR_KEEP,    // compaction: current entry to slot 'kept'
    WR_UPDATE,  // reader count change in place
    WR_APPEND,  // new handle at slot 'kept'
    WR_SHIFT    // current entry one slot down
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_KEPT,
    CNT_KEPT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    HS_Q,
    HS_ID,
    HS_ZERO
  } hsel_t;

  typedef struct packed {
    logic    accept;
    logic    step;
    wr_op_t  wr;
    cnt_op_t cnt;
    logic    emit;
    kind_t   kind;
    hsel_t   hsel;
    logic    last;
  } ctrl_t;

  typedef struct packed {
    logic count_zero;
    logic q_rz;       // entry under the pointer has no readers
    logic q_match;    // entry under the pointer holds the latched handle
    logic at_end;     // pointer is on the newest entry
    logic upd_zero;   // release leaves the entry with no readers
    logic kept_full;
    logic out_free;
  } stat_t;

endpackage

// ===== design/refcounted_frame_buffer_table.sv =====
// Commands are handled one at a time: push walks all entries held, take reads only the
//   newest entry, release walks until the handle matches or the table ends and shifts
//   the entries above a removed handle down; output stalls hold any command, and an
//   unused cmd is taken and dropped.
// Reset (rst, synchronous, active high) empties the table and the output register;
//   entry memory contents are not cleared.
module refcounted_frame_buffer_table #(
  parameter int TABLE_DEPTH = rfbt_pkg::TABLE_DEPTH_DEF,
  parameter int HANDLE_BITS = rfbt_pkg::HANDLE_BITS_DEF,
  parameter int READER_BITS = rfbt_pkg::READER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Command item
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [rfbt_pkg::ID_W-1:0]   s_axis_tdata,   // [7:0] buffer_id
  input  logic [rfbt_pkg::CMD_W-1:0]  s_axis_tuser,   // [1:0] cmd
  // Result item
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [rfbt_pkg::ID_W-1:0]   m_axis_tdata,   // [7:0] handle_out
  output logic [rfbt_pkg::KIND_W-1:0] m_axis_tuser,   // [2:0] kind
  output logic                        m_axis_tlast    // last result of the command
);
  import rfbt_pkg::*;

  // The sequencer takes a command only when it is idle. The result register in the
  // datapath decouples the two sides: a command can be taken while the previous
  // command's last result is still waiting downstream, and the sequencer only
  // stalls at the point where it must hand over its next result.
  //
  // Entries live in a small memory with one write and one read port, oldest first, each word holding
  // {handle, readers}. Reads are registered, and the walk pipelines them: the word
  // for entry i is examined while the read for i + 1 is issued.
  //   push    - walk all entries, return those with no readers, write the rest
  //             back at a trailing 'kept' pointer, then append or reject.
  //   take    - read the newest entry, bump its readers (saturating), grant.
  //   release - walk until the handle matches; drop a reader, and when none are
  //             left return it and shift the entries above it down one slot.

  ctrl_t ctrl;
  stat_t stat;

  rfbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  rfbt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .READER_BITS (READER_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .in_cmd     (s_axis_tuser),
    .in_id      (s_axis_tdata),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .out_handle (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

// ===== design/rfbt_ctrl.sv =====
module rfbt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [rfbt_pkg::CMD_W-1:0] in_cmd,
  output logic                       in_ready,
  input  rfbt_pkg::stat_t            stat,
  output rfbt_pkg::ctrl_t            ctrl
);
  import rfbt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_PUSH:    state_next = stat.count_zero ? ST_APPEND : ST_WALK;
            CMD_TAKE:    state_next = stat.count_zero ? ST_EMPTY : ST_GRANT;
            CMD_RELEASE: state_next = stat.count_zero ? ST_NOTF : ST_FIND;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if ((!stat.q_rz || stat.out_free) && stat.at_end) begin
          state_next = ST_APPEND;
        end
      end
      ST_APPEND, ST_GRANT, ST_EMPTY, ST_NOTF: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FIND: begin
        if (stat.q_match) begin
          if (stat.out_free) begin
            state_next = (stat.upd_zero && !stat.at_end) ? ST_SHIFT : ST_IDLE;
          end
        end else if (stat.at_end) begin
          state_next = ST_NOTF;
        end
      end
      ST_SHIFT: begin
        if (stat.at_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctrl     = '{accept: 1'b0, step: 1'b0, wr: WR_NONE, cnt: CNT_HOLD, emit: 1'b0,
                 kind: K_RETURNED, hsel: HS_Q, last: 1'b0};
    unique case (state)
      ST_IDLE: begin
        in_ready    = !rst;
        ctrl.accept = in_valid && !rst;
      end
      ST_WALK: begin
        if (stat.q_rz) begin
          if (stat.out_free) begin
            ctrl.emit = 1'b1;
            ctrl.kind = K_RETURNED;
            ctrl.hsel = HS_Q;
            ctrl.step = !stat.at_end;
          end
        end else begin
          ctrl.wr   = WR_KEEP;
          ctrl.step = !stat.at_end;
        end
      end
      ST_APPEND: begin
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          ctrl.hsel = HS_ID;
          ctrl.last = 1'b1;
          if (stat.kept_full) begin
            ctrl.kind = K_REJECTED;
            ctrl.cnt  = CNT_KEPT;
          end else begin
            ctrl.kind = K_STORED;
            ctrl.wr   = WR_APPEND;
            ctrl.cnt  = CNT_KEPT_INC;
          end
        end
      end
      ST_GRANT: begin
        if (stat.out_free) begin
          ctrl.wr   = WR_UPDATE;
          ctrl.emit = 1'b1;
          ctrl.kind = K_GRANTED;
          ctrl.hsel = HS_Q;
          ctrl.last = 1'b1;
        end
      end
      ST_EMPTY: begin
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          ctrl.kind = K_EMPTY;
          ctrl.hsel = HS_ZERO;
          ctrl.last = 1'b1;
        end
      end
      ST_NOTF: begin
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          ctrl.kind = K_NOTFOUND;
          ctrl.hsel = HS_ID;
          ctrl.last = 1'b1;
        end
      end
      ST_FIND: begin
        if (stat.q_match) begin
          if (stat.out_free) begin
            ctrl.emit = 1'b1;
            ctrl.hsel = HS_Q;
            ctrl.last = 1'b1;
            if (stat.upd_zero) begin
              ctrl.kind = K_RETURNED;
              if (stat.at_end) begin
                ctrl.cnt = CNT_DEC;
              end else begin
                ctrl.step = 1'b1;
              end
            end else begin
              ctrl.kind = K_HELD;
              ctrl.wr   = WR_UPDATE;
            end
          end
        end else begin
          ctrl.step = !stat.at_end;
        end
      end
      ST_SHIFT: begin
        ctrl.wr = WR_SHIFT;
        if (stat.at_end) begin
          ctrl.cnt = CNT_DEC;
        end else begin
          ctrl.step = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/rfbt_dpath.sv =====
module rfbt_dpath #(
  parameter int TABLE_DEPTH = rfbt_pkg::TABLE_DEPTH_DEF,
  parameter int HANDLE_BITS = rfbt_pkg::HANDLE_BITS_DEF,
  parameter int READER_BITS = rfbt_pkg::READER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rfbt_pkg::CMD_W-1:0]  in_cmd,
  input  logic [rfbt_pkg::ID_W-1:0]   in_id,
  input  rfbt_pkg::ctrl_t             ctrl,
  output rfbt_pkg::stat_t             stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rfbt_pkg::KIND_W-1:0] out_kind,
  output logic [rfbt_pkg::ID_W-1:0]   out_handle,
  output logic                        out_last
);
  import rfbt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = HANDLE_BITS + READER_BITS;
  localparam int CB = (HANDLE_BITS < ID_W) ? HANDLE_BITS : ID_W;

  logic [EW-1:0]          mem [TABLE_DEPTH];
  logic [EW-1:0]          q;
  logic [IW-1:0]          idx;
  logic [IW-1:0]          raddr;
  logic [IW-1:0]          start_idx;
  logic [IW-1:0]          waddr;
  logic [EW-1:0]          wdata;
  logic                   we;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_m1;
  logic [CW-1:0]          kept;
  logic [HANDLE_BITS-1:0] id_q;
  logic [HANDLE_BITS-1:0] id_in;
  logic [CMD_W-1:0]       cmd_q;
  logic [HANDLE_BITS-1:0] q_handle;
  logic [READER_BITS-1:0] q_readers;
  logic [READER_BITS-1:0] rd_upd;
  logic [HANDLE_BITS-1:0] emit_handle;
  logic [ID_W-1:0]        emit_port;
  logic [IW-1:0]          idx_dn;

  assign q_handle  = q[EW-1:READER_BITS];
  assign q_readers = q[READER_BITS-1:0];
  assign count_m1  = count - CW'(1);
  assign idx_dn    = idx - IW'(1);

  always_comb begin
    id_in = '0;
    for (int b = 0; b < CB; b++) begin
      id_in[b] = in_id[b];
    end
  end

  // Reader count after a take (saturating) or a release (floored at zero)
  always_comb begin
    if (cmd_q == CMD_TAKE) begin
      rd_upd = (q_readers == '1) ? q_readers : q_readers + READER_BITS'(1);
    end else begin
      rd_upd = (q_readers == '0) ? q_readers : q_readers - READER_BITS'(1);
    end
  end

  assign start_idx = (in_cmd == CMD_TAKE) ? count_m1[IW-1:0] : '0;

  always_comb begin
    if (ctrl.accept) begin
      raddr = start_idx;
    end else if (ctrl.step) begin
      raddr = idx + IW'(1);
    end else begin
      raddr = idx;
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = idx;
    wdata = q;
    case (ctrl.wr)
      WR_KEEP:   waddr = kept[IW-1:0];
      WR_UPDATE: wdata = {q_handle, rd_upd};
      WR_APPEND: begin
        waddr = kept[IW-1:0];
        wdata = {id_q, {READER_BITS{1'b0}}};
      end
      WR_SHIFT:  waddr = idx_dn;
      default:   we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (ctrl.cnt)
        CNT_KEPT:     count <= kept;
        CNT_KEPT_INC: count <= kept + CW'(1);
        CNT_DEC:      count <= count_m1;
        default:      count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      idx   <= start_idx;
      kept  <= '0;
      id_q  <= id_in;
      cmd_q <= in_cmd;
    end else begin
      if (ctrl.step) begin
        idx <= idx + IW'(1);
      end
      if (ctrl.wr == WR_KEEP) begin
        kept <= kept + CW'(1);
      end
    end
  end

  always_comb begin
    case (ctrl.hsel)
      HS_Q:    emit_handle = q_handle;
      HS_ID:   emit_handle = id_q;
      default: emit_handle = '0;
    endcase
    emit_port = '0;
    for (int b = 0; b < CB; b++) begin
      emit_port[b] = emit_handle[b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_kind   <= ctrl.kind;
      out_handle <= emit_port;
      out_last   <= ctrl.last;
    end
  end

  assign stat.count_zero = (count == '0);
  assign stat.q_rz       = (q_readers == '0);
  assign stat.q_match    = (q_handle == id_q);
  assign stat.at_end     = ((CW'(idx) + CW'(1)) == count);
  assign stat.upd_zero   = (q_readers <= READER_BITS'(1));
  assign stat.kept_full  = (kept == CW'(TABLE_DEPTH));
  assign stat.out_free   = !out_valid || out_ready;

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> (!out_valid || out_ready))
    else $error("result produced while output register still occupied");

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.wr == WR_KEEP || ctrl.wr == WR_APPEND) |-> (kept < CW'(TABLE_DEPTH)))
    else $error("table write beyond its depth");

  a_store_count: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit && ctrl.kind == K_STORED) |=> (count != '0 && count <= CW'(TABLE_DEPTH)))
    else $error("entry count wrong after a stored handle");

endmodule
